// ----- sv/wsac_pkg.sv -----
// ----------------------------------------------------------------------------
// wsac_pkg: shared types and constants
// Drive codes, register indexes, reset values and the stage control bundle
// of the wheel speed anti-skid controller.
// ----------------------------------------------------------------------------
`default_nettype none

package wsac_pkg;

   localparam int SPEED_W = 16;

   typedef logic [SPEED_W-1:0]  speed_type;
   typedef logic signed [1:0]   drive_type;

   localparam drive_type DRIVE_NONE    = 2'sb00;
   localparam drive_type DRIVE_ACCEL   = 2'sb01;
   localparam drive_type DRIVE_BRAKE   = 2'sb10;
   localparam drive_type DRIVE_RELEASE = 2'sb11;

   typedef enum logic [1:0] {
      CSR_TARGET_SPEED    = 2'd0,
      CSR_DROP_THRESHOLD  = 2'd1,
      CSR_ANTISKID_ENABLE = 2'd2
   } csr_index_type;

   localparam speed_type TARGET_SPEED_RESET   = 16'd110;
   localparam speed_type DROP_THRESHOLD_RESET = 16'd50;
   localparam logic      ANTISKID_RESET       = 1'b1;

   // control bundle of a beat between the window stage and the decision stage
   typedef struct packed {
      logic      closed;
      logic      blocked;
      logic      crash;
      logic      antiskid;
      speed_type target;
   } stage_type;

endpackage

`default_nettype wire

// ----- sv/wheel_speed_antiskid_controller.sv -----
// ----------------------------------------------------------------------------
// wheel_speed_antiskid_controller: wheel speed anti-skid controller
// Crash latch on a sudden speed drop, windowed averaging and a drive command
// at the end of each window.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one 16-bit wheel speed sample per beat. Every accepted
//   sample yields exactly one beat on rsp_*: rsp_tuser is high when that
//   sample closed a window of WINDOW samples and the drive field is new;
//   otherwise drive repeats the last command and average/blocked read zero.
//   Each accepted sample passes the input register, then the result register,
//   before rsp_tvalid rises; one beat per cycle is sustained while rsp_tready
//   is high, with the window accumulator loop (sum, count, crash latch)
//   updated on each accepted sample. The average comes from a multiply by the
//   reciprocal of WINDOW in the decision stage.
//   csr_* writes target_speed (0), drop_threshold (1), antiskid_enable (2);
//   other indexes are ignored. Write only while idle.
//   Reset (synchronous) empties the pipeline, clears the window, the crash
//   latch and the last command, and loads the register defaults.
//   When rsp_tready is low the result holds and the pipeline stalls;
//   req_tready drops only once both stages hold beats.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_speed_antiskid_controller #(
   parameter int WINDOW = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [15:0] speed_sample
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [1:0] drive, [17:2] window_average,
                                    // [18] wheel_blocked, [19] crash_latched
   output logic        rsp_tuser,   // [0] action_valid
   input  wire         csr_wen,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata
);

   localparam int LOG_W = $clog2(WINDOW);
   localparam int SUM_W = 16 + LOG_W;
   localparam int CNT_W = LOG_W;
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(WINDOW - 1);

   // configuration
   wsac_pkg::speed_type target_ff, threshold_ff;
   logic                antiskid_ff;

   // window state
   wsac_pkg::speed_type prev_sample_ff, prev_sample_in;
   wsac_pkg::speed_type prev_end_ff, prev_end_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                crash_ff, crash_in;

   // decision stage input
   logic                s1_valid_ff, s1_valid_in;
   wsac_pkg::stage_type s1_ctl_ff, s1_ctl_in;
   logic [SUM_W-1:0]    s1_sum_ff, s1_sum_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_action_ff;
   wsac_pkg::drive_type rsp_drive_ff, rsp_drive_in;
   wsac_pkg::speed_type rsp_avg_ff;
   logic                rsp_blocked_ff, rsp_crash_ff;
   wsac_pkg::drive_type last_drive_ff;

   wsac_pkg::speed_type sample, law_avg;
   wsac_pkg::drive_type law_drive;
   logic                accept, advance, closing, drop;
   logic [SUM_W-1:0]    sum_next;

   assign sample     = req_tdata;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign drop     = (prev_sample_ff >= sample) && ((prev_sample_ff - sample) >= threshold_ff);
   assign closing  = (count_ff == LAST_COUNT);
   assign sum_next = sum_ff + SUM_W'(sample);

   always_comb begin
      crash_in       = crash_ff;
      prev_sample_in = prev_sample_ff;
      prev_end_in    = prev_end_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      s1_ctl_in      = s1_ctl_ff;
      s1_sum_in      = s1_sum_ff;
      s1_valid_in    = s1_valid_ff && !advance;
      if (accept) begin
         crash_in       = crash_ff || drop;
         prev_sample_in = sample;
         s1_valid_in    = 1'b1;
         s1_sum_in      = sum_next;
         s1_ctl_in.closed   = closing;
         s1_ctl_in.blocked  = closing && (sample == prev_end_ff);
         s1_ctl_in.crash    = crash_in;
         s1_ctl_in.antiskid = antiskid_ff;
         s1_ctl_in.target   = crash_in ? '0 : target_ff;
         if (closing) begin
            sum_in      = '0;
            count_in    = '0;
            prev_end_in = sample;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + 1'b1;
         end
      end
   end

   wsac_law #(
      .WINDOW (WINDOW)
   ) u_law (
      .ctl_i     (s1_ctl_ff),
      .sum_i     (s1_sum_ff),
      .average_o (law_avg),
      .drive_o   (law_drive)
   );

   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   assign rsp_drive_in = s1_ctl_ff.closed ? law_drive : last_drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff      <= wsac_pkg::TARGET_SPEED_RESET;
         threshold_ff   <= wsac_pkg::DROP_THRESHOLD_RESET;
         antiskid_ff    <= wsac_pkg::ANTISKID_RESET;
         prev_sample_ff <= '0;
         prev_end_ff    <= '0;
         sum_ff         <= '0;
         count_ff       <= '0;
         crash_ff       <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_drive_ff  <= wsac_pkg::DRIVE_NONE;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               wsac_pkg::CSR_TARGET_SPEED:    target_ff    <= csr_wdata;
               wsac_pkg::CSR_DROP_THRESHOLD:  threshold_ff <= csr_wdata;
               wsac_pkg::CSR_ANTISKID_ENABLE: antiskid_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         prev_sample_ff <= prev_sample_in;
         prev_end_ff    <= prev_end_in;
         sum_ff         <= sum_in;
         count_ff       <= count_in;
         crash_ff       <= crash_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance && s1_valid_ff && s1_ctl_ff.closed) begin
            last_drive_ff <= law_drive;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff <= s1_ctl_in;
      s1_sum_ff <= s1_sum_in;
      if (advance && s1_valid_ff) begin
         rsp_action_ff  <= s1_ctl_ff.closed;
         rsp_drive_ff   <= rsp_drive_in;
         rsp_avg_ff     <= s1_ctl_ff.closed ? law_avg : '0;
         rsp_blocked_ff <= s1_ctl_ff.blocked;
         rsp_crash_ff   <= s1_ctl_ff.crash;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_action_ff;
   assign rsp_tdata  = {4'b0000, rsp_crash_ff, rsp_blocked_ff, rsp_avg_ff, rsp_drive_ff};

`ifndef NO_ASSERTIONS
   a_crash_sticks : assert property (@(posedge clock) disable iff (reset)
      crash_ff |=> crash_ff)
      else $error("crash latch cleared without reset");

   a_window_wraps : assert property (@(posedge clock) disable iff (reset)
      accept && closing |=> count_ff == '0 && sum_ff == '0)
      else $error("window state not cleared after closing sample");

   a_idle_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_action_ff |-> rsp_avg_ff == '0 && !rsp_blocked_ff)
      else $error("non-closing result carries average or blocked flag");

   a_action_sets_drive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_action_ff |-> rsp_drive_ff != wsac_pkg::DRIVE_NONE)
      else $error("closed window without a drive command");

   a_last_drive_sticks : assert property (@(posedge clock) disable iff (reset)
      last_drive_ff != wsac_pkg::DRIVE_NONE |=> last_drive_ff != wsac_pkg::DRIVE_NONE)
      else $error("last drive command returned to none");
`endif

endmodule

`default_nettype wire

// ----- sv/wsac_law.sv -----
// ----------------------------------------------------------------------------
// wsac_law: window average and drive decision
// Divides the window sum by the window length through a constant reciprocal
// and applies the control law with the anti-skid rule at a zero target.
// ----------------------------------------------------------------------------
`default_nettype none

module wsac_law #(
   parameter int WINDOW = 8
) (
   input  wire wsac_pkg::stage_type          ctl_i,
   input  wire [16+$clog2(WINDOW)-1:0]       sum_i,
   output wsac_pkg::speed_type               average_o,
   output wsac_pkg::drive_type               drive_o
);

   localparam int LOG_W  = $clog2(WINDOW);
   localparam int SUM_W  = 16 + LOG_W;
   localparam int SHIFT  = SUM_W + LOG_W;
   localparam int PROD_W = 2 * SUM_W + 1;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];

   logic [PROD_W-1:0]   product;
   wsac_pkg::speed_type average;

   assign product   = PROD_W'(sum_i) * PROD_W'(RECIP);
   assign average   = product[SHIFT +: 16];
   assign average_o = average;

   always_comb begin
      if (ctl_i.target == '0) begin
         if (ctl_i.antiskid && average != '0 && ctl_i.blocked) begin
            drive_o = wsac_pkg::DRIVE_RELEASE;
         end else begin
            drive_o = wsac_pkg::DRIVE_BRAKE;
         end
      end else if (average < ctl_i.target) begin
         drive_o = wsac_pkg::DRIVE_ACCEL;
      end else if (average > ctl_i.target) begin
         drive_o = wsac_pkg::DRIVE_RELEASE;
      end else begin
         drive_o = wsac_pkg::DRIVE_BRAKE;
      end
   end

endmodule

`default_nettype wire

// ----- tb/drive_command_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_command_checker: result checker for the anti-skid controller
// Watches the sample, result and register ports. Keeps its own copy of the
// crash latch, window sum and drive history, works out the result beat for
// every accepted sample and compares it field by field with the DUT.
// ----------------------------------------------------------------------------

module drive_command_checker #(
   parameter int WINDOW = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [15:0] req_tdata,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [23:0] rsp_tdata,
   input  wire         rsp_tuser,
   input  wire         csr_wen,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata,
   output int          mismatches,
   output int          pending_results
);

   typedef struct packed {
      logic                action;
      wsac_pkg::drive_type drive;
      wsac_pkg::speed_type average;
      logic                blocked;
      logic                crash;
   } wheel_result_type;

   wsac_pkg::speed_type target_reg;
   wsac_pkg::speed_type threshold_reg;
   logic                antiskid_reg;

   wsac_pkg::speed_type last_speed;
   wsac_pkg::speed_type last_close_speed;
   logic [18:0]         window_sum;
   int                  window_fill;
   logic                crash_seen;
   wsac_pkg::drive_type held_drive;

   wheel_result_type    expected_beats[$];
   int                  beat_count;

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatches++;
      $display("%0t ns: beat %0d %s: got %0h, expected %0h",
               $time, beat_count, field, got, want);
   endtask

   task automatic step_wheel(input wsac_pkg::speed_type s, output wheel_result_type r);
      wsac_pkg::speed_type goal;
      wsac_pkg::drive_type d;
      r = '0;
      if (last_speed >= s && wsac_pkg::speed_type'(last_speed - s) >= threshold_reg)
         crash_seen = 1'b1;
      last_speed = s;
      window_sum = window_sum + s;
      window_fill++;
      if (window_fill >= WINDOW) begin
         goal = crash_seen ? wsac_pkg::speed_type'(0) : target_reg;
         r.action = 1'b1;
         r.average = wsac_pkg::speed_type'(window_sum / WINDOW);
         window_sum = '0;
         window_fill = 0;
         r.blocked = (s == last_close_speed);
         last_close_speed = s;
         if (r.average < goal)
            d = wsac_pkg::DRIVE_ACCEL;
         else if (r.average > goal)
            d = wsac_pkg::DRIVE_RELEASE;
         else
            d = wsac_pkg::DRIVE_BRAKE;
         // zero target: anti-skid releases only a blocked, moving wheel
         if (goal == 0) begin
            if (antiskid_reg) begin
               if (r.average != 0 && !r.blocked)
                  d = wsac_pkg::DRIVE_BRAKE;
            end else begin
               d = wsac_pkg::DRIVE_BRAKE;
            end
         end
         held_drive = d;
      end
      r.drive = held_drive;
      r.crash = crash_seen;
   endtask

   always @(posedge clock) begin
      wheel_result_type got;
      wheel_result_type want;
      if (reset) begin
         target_reg = wsac_pkg::TARGET_SPEED_RESET;
         threshold_reg = wsac_pkg::DROP_THRESHOLD_RESET;
         antiskid_reg = wsac_pkg::ANTISKID_RESET;
         last_speed = '0;
         last_close_speed = '0;
         window_sum = '0;
         window_fill = 0;
         crash_seen = 1'b0;
         held_drive = wsac_pkg::DRIVE_NONE;
         expected_beats.delete();
         beat_count = 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               wsac_pkg::CSR_TARGET_SPEED:    target_reg = csr_wdata;
               wsac_pkg::CSR_DROP_THRESHOLD:  threshold_reg = csr_wdata;
               wsac_pkg::CSR_ANTISKID_ENABLE: antiskid_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            step_wheel(req_tdata, want);
            expected_beats.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.action = rsp_tuser;
            got.drive = rsp_tdata[1:0];
            got.average = rsp_tdata[17:2];
            got.blocked = rsp_tdata[18];
            got.crash = rsp_tdata[19];
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata[15:0], '0);
            end else begin
               want = expected_beats.pop_front();
               if (got.action !== want.action)
                  report_mismatch("action_valid", got.action, want.action);
               if (got.drive !== want.drive)
                  report_mismatch("drive", got.drive, want.drive);
               if (got.average !== want.average)
                  report_mismatch("window_average", got.average, want.average);
               if (got.blocked !== want.blocked)
                  report_mismatch("wheel_blocked", got.blocked, want.blocked);
               if (got.crash !== want.crash)
                  report_mismatch("crash_latched", got.crash, want.crash);
            end
            beat_count++;
         end
      end
      pending_results = expected_beats.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for wheel_speed_antiskid_controller
// Drives speed samples as smooth trajectories with held windows and noise,
// walks the registers through several settings between drained phases, sets
// the crash latch late in the run and stalls both channels at random.
// ----------------------------------------------------------------------------

module tb;

   localparam int WINDOW = 8;
   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wen;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   int          mismatches;
   int          pending_results;

   wsac_pkg::speed_type cur_speed;
   int          sent_count;
   int          calm;
   bit          quiet;
   bit          holding;

   wheel_speed_antiskid_controller #(.WINDOW(WINDOW)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   drive_command_checker #(.WINDOW(WINDOW)) checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .pending_results(pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("** wheel_speed_antiskid_controller: FAILED **");
      $finish;
   end

   // result side back-pressure
   initial begin
      int stall_left;
      int free_left;
      stall_left = 0;
      free_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet) begin
            rsp_tready <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (free_left != 0) begin
            rsp_tready <= 1'b1;
            free_left--;
         end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_tready <= 1'b0;
         end else begin
            free_left = $urandom_range(1, 40) - 1;
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic pause_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata <= 16'($urandom);
      end
   endtask

   task automatic send_sample(input wsac_pkg::speed_type s);
      if (calm > 0)
         calm--;
      else if (!quiet && $urandom_range(0, 15) == 0)
         calm = $urandom_range(20, 60);
      if (!quiet && calm == 0 && $urandom_range(0, 3) == 0)
         pause_sender($urandom_range(1, 6));
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // speed trajectory around center; whole windows may hold one value
   task automatic run_walk(input int n, input wsac_pkg::speed_type center,
                           input int step_max, input int noise_pct);
      int v;
      wsac_pkg::speed_type s;
      for (int k = 0; k < n; k++) begin
         if (sent_count % WINDOW == 0)
            holding = ($urandom_range(0, 2) == 0);
         if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct) begin
            s = wsac_pkg::speed_type'($urandom);
         end else begin
            if (!holding) begin
               v = int'(cur_speed) + int'($urandom_range(0, 2 * step_max)) - step_max;
               if (v > int'(center) + 4 * step_max) v -= step_max;
               if (v < int'(center) - 4 * step_max) v += step_max;
               if (v < 0) v = 0;
               if (v > 65535) v = 65535;
               cur_speed = wsac_pkg::speed_type'(v);
            end
            s = cur_speed;
         end
         send_sample(s);
      end
   endtask

   initial begin
      wsac_pkg::speed_type goal;
      int gap;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cur_speed = '0;
      sent_count = 0;
      calm = 0;
      quiet = 1'b0;
      holding = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults: first window ends on zero (blocked), then equal
      // to target, then above target
      repeat (WINDOW) send_sample(16'd0);
      repeat (WINDOW) send_sample(16'd110);
      for (int k = 1; k <= WINDOW; k++) send_sample(wsac_pkg::speed_type'(110 + k));
      cur_speed = 16'd118;
      run_walk(90, 16'd110, 12, 0);
      drain();

      // zero target with anti-skid on, then off
      write_csr(wsac_pkg::CSR_TARGET_SPEED, 16'd0);
      write_csr(wsac_pkg::CSR_DROP_THRESHOLD, 16'hFFFF);
      write_csr(wsac_pkg::CSR_ANTISKID_ENABLE, {15'($urandom), 1'b1});
      write_csr(CSR_SPARE_INDEX, 16'($urandom));
      run_walk(110, 16'd6, 2, 10);
      drain();
      write_csr(wsac_pkg::CSR_ANTISKID_ENABLE, {15'($urandom), 1'b0});
      run_walk(70, 16'd6, 2, 10);
      drain();

      // top of the speed range
      write_csr(wsac_pkg::CSR_TARGET_SPEED, 16'hFFFF);
      write_csr(wsac_pkg::CSR_DROP_THRESHOLD, 16'($urandom_range(1000, 5000)));
      write_csr(wsac_pkg::CSR_ANTISKID_ENABLE, {15'($urandom), 1'b1});
      cur_speed = 16'd65530;
      run_walk(80, 16'd65530, 4, 0);
      drain();

      // random settings; threshold clears the jump to the new target
      repeat (3) begin
         goal = wsac_pkg::speed_type'($urandom);
         gap = (cur_speed > goal) ? int'(cur_speed - goal) + 1 : 100;
         if (gap < 100) gap = 100;
         write_csr(wsac_pkg::CSR_TARGET_SPEED, goal);
         write_csr(wsac_pkg::CSR_DROP_THRESHOLD, 16'($urandom_range(gap, 65535)));
         write_csr(wsac_pkg::CSR_ANTISKID_ENABLE, 16'($urandom));
         cur_speed = goal;
         run_walk(70, goal, $urandom_range(1, 40), 0);
         drain();
      end

      // crash latched by the sample that closes a window
      write_csr(wsac_pkg::CSR_DROP_THRESHOLD, 16'hFFFF);
      while (sent_count % WINDOW != 0) send_sample(cur_speed);
      for (int k = 0; k < WINDOW - 1; k++) send_sample(wsac_pkg::speed_type'(1000 + k));
      drain();
      write_csr(wsac_pkg::CSR_DROP_THRESHOLD, 16'd0);
      send_sample(wsac_pkg::speed_type'(1000 + WINDOW - 2));
      send_sample(16'hFFFF);
      send_sample(16'd0);
      send_sample(16'hFFFF);
      send_sample(16'hFFFF);
      drain();

      // latched crash: zero target regardless of register
      write_csr(wsac_pkg::CSR_TARGET_SPEED, 16'($urandom));
      write_csr(wsac_pkg::CSR_DROP_THRESHOLD, 16'd1);
      write_csr(wsac_pkg::CSR_ANTISKID_ENABLE, {15'($urandom), 1'b1});
      cur_speed = 16'd5;
      run_walk(100, 16'd5, 2, 20);
      drain();

      write_csr(wsac_pkg::CSR_ANTISKID_ENABLE, {15'($urandom), 1'b0});
      quiet = 1'b1;
      run_walk(70, 16'd5, 2, 50);
      drain();

      if (mismatches == 0)
         $display("** wheel_speed_antiskid_controller: PASSED **");
      else
         $display("** wheel_speed_antiskid_controller: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/wsac_pkg.sv
sv/wsac_law.sv
sv/wheel_speed_antiskid_controller.sv
tb/drive_command_checker.sv
tb/tb.sv
